>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define KFDC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define KFDC_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> rtl/kfdc_pkg.sv
`default_nettype none

package kfdc_pkg;

  localparam int unsigned KEY_BITS    = 31;
  localparam int unsigned ACTION_BITS = 2;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_SEARCH = 2'd3
  } action_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_NONE = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/kfdc_in_if.sv
`default_nettype none

interface kfdc_in_if #(
  parameter int unsigned HANDLE_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic [kfdc_pkg::ACTION_BITS-1:0]    action;
  logic [kfdc_pkg::KEY_BITS-1:0]       key;
  logic [HANDLE_BITS-1:0]              handle;

  modport source (output valid, output action, output key, output handle, input ready);
  modport sink   (input valid, input action, input key, input handle, output ready);
endinterface

`default_nettype wire

>>> rtl/kfdc_out_if.sv
`default_nettype none

interface kfdc_out_if #(
  parameter int unsigned HANDLE_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic [kfdc_pkg::STATUS_BITS-1:0]    status;
  logic [kfdc_pkg::KEY_BITS-1:0]       key_out;
  logic [HANDLE_BITS-1:0]              handle_out;
  logic                                is_empty;

  modport source (output valid, output status, output key_out, output handle_out,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input key_out, input handle_out,
                  input is_empty, output ready);
endinterface

`default_nettype wire

>>> rtl/kfdc_datapath.sv
`default_nettype none

`include "assert_macros.svh"

module kfdc_datapath #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire kfdc_pkg::cmd_t                 cmd_i,
  output kfdc_pkg::sts_t                      sts_o,
  input  wire [kfdc_pkg::ACTION_BITS-1:0]     action_i,
  input  wire [kfdc_pkg::KEY_BITS-1:0]        key_i,
  input  wire [HANDLE_BITS-1:0]               handle_i,
  output logic [kfdc_pkg::STATUS_BITS-1:0]    status_o,
  output logic [kfdc_pkg::KEY_BITS-1:0]       key_out_o,
  output logic [HANDLE_BITS-1:0]              handle_out_o,
  output logic                                is_empty_o
);

  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_W = kfdc_pkg::KEY_BITS + HANDLE_BITS;

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rd_q;

  logic [AW-1:0] head_q, head_d, tail_q, tail_d, ptr_q, ptr_nxt;
  logic [CW-1:0] count_q, count_d, issued_q, limit_q;
  logic          rd_vld_q, hit_q, any_q;
  kfdc_pkg::action_e              act_q;
  logic [kfdc_pkg::KEY_BITS-1:0]  key_q;
  logic [HANDLE_BITS-1:0]         hnd_q;

  logic [kfdc_pkg::KEY_BITS-1:0]  rd_key;
  logic [HANDLE_BITS-1:0]         rd_hnd;
  logic                           match, issue, in_any, full, ins_ok, rem_ok;
  kfdc_pkg::status_e              status_d;
  logic                           ret_rec;

  assign rd_key = rd_q[ENTRY_W-1 -: kfdc_pkg::KEY_BITS];
  assign rd_hnd = rd_q[HANDLE_BITS-1:0];

  // remove and peek take the first entry read, whatever its key
  assign in_any = (kfdc_pkg::action_e'(action_i) == kfdc_pkg::ACT_REMOVE) ||
                  (kfdc_pkg::action_e'(action_i) == kfdc_pkg::ACT_PEEK);
  assign match  = rd_vld_q && (any_q || (rd_key == key_q));
  assign issue  = cmd_i.scan && (issued_q != limit_q) && !hit_q && !match;
  assign ptr_nxt = (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;

  assign sts_o.scan_done = !rd_vld_q && (hit_q || (issued_q == limit_q));

  assign full   = (count_q == CW'(DEPTH));
  assign ins_ok = (act_q == kfdc_pkg::ACT_INSERT) && !hit_q && !full;
  assign rem_ok = (act_q == kfdc_pkg::ACT_REMOVE) && hit_q;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    status_d = kfdc_pkg::ST_NONE;
    ret_rec  = 1'b0;
    unique case (act_q)
      kfdc_pkg::ACT_INSERT: begin
        if (hit_q) begin
          status_d = kfdc_pkg::ST_DUP;
        end else if (full) begin
          status_d = kfdc_pkg::ST_FULL;
        end else begin
          status_d = kfdc_pkg::ST_OK;
          tail_d   = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
          count_d  = count_q + 1'b1;
        end
      end
      kfdc_pkg::ACT_REMOVE, kfdc_pkg::ACT_PEEK, kfdc_pkg::ACT_SEARCH: begin
        if (hit_q) begin
          status_d = kfdc_pkg::ST_OK;
          ret_rec  = 1'b1;
        end
        if (rem_ok) begin
          head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        status_d = kfdc_pkg::ST_NONE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      issued_q <= '0;
      limit_q  <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (cmd_i.load) begin
        issued_q <= '0;
        hit_q    <= 1'b0;
        if (in_any) begin
          limit_q <= (count_q != '0) ? CW'(1) : '0;
        end else begin
          limit_q <= count_q;
        end
      end else begin
        if (issue) begin
          issued_q <= issued_q + 1'b1;
        end
        if (match) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= kfdc_pkg::action_e'(action_i);
      key_q <= key_i;
      hnd_q <= handle_i;
      any_q <= in_any;
      ptr_q <= head_q;
    end else if (issue) begin
      ptr_q <= ptr_nxt;
    end
    if (cmd_i.commit) begin
      status_o     <= status_d;
      key_out_o    <= ret_rec ? rd_key : '0;
      handle_out_o <= ret_rec ? rd_hnd : '0;
      is_empty_o   <= (count_d == '0);
    end
  end

  // record memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q <= mem_q[ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && ins_ok) begin
      mem_q[tail_q] <= {key_q, hnd_q};
    end
  end

  `KFDC_ASSERT(a_count_range, count_q <= CW'(DEPTH), "entry count above depth")
  `KFDC_ASSERT(a_scan_bound, issued_q <= limit_q, "scan read past held entries")
  `KFDC_ASSERT_NEXT(a_empty_flag, cmd_i.commit, is_empty_o == (count_q == '0),
                    "empty flag disagrees with entry count")
  `KFDC_ASSERT_NEXT(a_hit_stops_scan, match, !rd_vld_q,
                    "memory read issued after a match")

endmodule

`default_nettype wire

>>> rtl/kfdc_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module kfdc_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output kfdc_pkg::cmd_t       cmd_o,
  input  wire kfdc_pkg::sts_t  sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.scan   = (state_q == S_SCAN);
  // result register must be free before a new result lands in it
  assign cmd_o.commit = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts_i.scan_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (cmd_o.commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `KFDC_ASSERT_NEXT(a_hold_result, (state_q == S_DONE) && out_valid_q && !out_ready_i,
                    state_q == S_DONE, "result written over an untaken transaction")
  `KFDC_ASSERT_NEXT(a_commit_valid, cmd_o.commit, out_valid_q && (state_q == S_IDLE),
                    "commit did not raise the result")

endmodule

`default_nettype wire

>>> rtl/keyed_fifo_with_duplicate_check.sv
`default_nettype none

// Keyed FIFO: a bounded queue of DEPTH records (31-bit key, HANDLE_BITS-bit handle) kept in a
// single-port-read, single-port-write memory. Actions are insert (refused with a duplicate
// status if the key is held, or a full status), remove head, peek head and search by key;
// every request transaction yields exactly one response transaction carrying the queue's
// empty flag after the action. One request is worked at a time. Insert and search scan the
// held entries from the head, one memory read per cycle, and a hit ends a search early.
// Remove and peek read the head slot once, or not at all if the queue is empty. A new
// request is taken while the previous response still waits to be picked up.
module keyed_fifo_with_duplicate_check #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  kfdc_in_if.sink     req_i,
  kfdc_out_if.source  rsp_o
);

  kfdc_pkg::cmd_t cmd;
  kfdc_pkg::sts_t sts;

  kfdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  kfdc_datapath #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .action_i     (req_i.action),
    .key_i        (req_i.key),
    .handle_i     (req_i.handle),
    .status_o     (rsp_o.status),
    .key_out_o    (rsp_o.key_out),
    .handle_out_o (rsp_o.handle_out),
    .is_empty_o   (rsp_o.is_empty)
  );

endmodule

`default_nettype wire
